FILE: sv/kcl_pkg.sv
// Package with the shared types, codes and constants of the keypad code-lock controller.
package kcl_pkg;

  localparam int CODE_LEN_DEF = 4;
  localparam int CARD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int POS_W        = 2;
  localparam int MODE_W       = 2;
  localparam int DIGIT_W      = 4;

  localparam logic [CARD_W-1:0] CARD_UID_RESET = 32'h59AE_0B7B;

  localparam logic [REQ_W-1:0] REQ_KEY  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CARD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LINK = 2'd2;

  localparam logic [BYTE_W-1:0] KEY_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] KEY_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] KEY_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] LINK_UNLOCK = 8'h41;

  localparam logic [MODE_W-1:0] LM_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] LM_OLD    = 2'd1;
  localparam logic [MODE_W-1:0] LM_NEW    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DIGIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CHANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NEWPROMPT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CHANGED   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_WRONGOLD  = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] key_code;
    logic [CARD_W-1:0] card_id;
    logic [BYTE_W-1:0] link_byte;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    digit_position;
    logic [MODE_W-1:0]   lock_mode;
    logic                unlock;
  } rsp_t;

  // Factory password digit for a given position.
  function automatic logic [DIGIT_W-1:0] reset_digit(input int idx);
    return DIGIT_W'((idx % 9) + 1);
  endfunction

endpackage

FILE: sv/kcl_if.sv
// Valid/ready channel interfaces for the request and response words.
interface kcl_req_if;
  import kcl_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] key_code;
  logic [CARD_W-1:0] card_id;
  logic [BYTE_W-1:0] link_byte;

  modport source (output valid, output req_type, output key_code, output card_id,
                  output link_byte, input ready);
  modport sink (input valid, input req_type, input key_code, input card_id,
                input link_byte, output ready);
endinterface

interface kcl_rsp_if;
  import kcl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    digit_position;
  logic [MODE_W-1:0]   lock_mode;
  logic                unlock;

  modport source (output valid, output status, output digit_position, output lock_mode,
                  output unlock, input ready);
  modport sink (input valid, input status, input digit_position, input lock_mode,
                input unlock, output ready);
endinterface

FILE: sv/kcl_stage.sv
// Pipeline register stage with valid/ready flow control for one word.
module kcl_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  T     in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output T     out_data_o
);

  logic valid_q;
  T     data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

FILE: sv/kcl_fsm.sv
// Lock state machine: mode, digit entry, stored password, card register and the result word.
module kcl_fsm #(
  parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kcl_pkg::CARD_W-1:0]  cfg_wdata_i,
  input  logic                        step_i,
  input  kcl_pkg::req_t               item_i,
  output kcl_pkg::rsp_t               rsp_o
);
  import kcl_pkg::*;

  localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LEN - 1);

  typedef enum logic [MODE_W-1:0] {
    NORMAL = LM_NORMAL,
    OLD_PW = LM_OLD,
    NEW_PW = LM_NEW
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic [CARD_W-1:0]    card_uid_q;
  logic [DIGIT_W-1:0]   entry_q [CODE_LEN];
  logic [DIGIT_W-1:0]   stored_q [CODE_LEN];
  logic [DIGIT_W-1:0]   entry_nx [CODE_LEN];
  logic [DIGIT_W-1:0]   digit;
  logic                 is_digit;
  logic                 is_normal;
  logic                 match;
  logic                 entry_we;
  logic                 store_we;

  assign digit    = item_i.key_code[DIGIT_W-1:0];
  assign is_digit = (item_i.key_code >= KEY_ZERO) && (item_i.key_code <= KEY_NINE);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      entry_nx[i] = (IDX_W'(i) == cnt_q) ? digit : entry_q[i];
      match       = match && (entry_nx[i] == stored_q[i]);
    end
  end

  always_comb begin
    case (mode_q)
      OLD_PW:  is_normal = 1'b0;
      NEW_PW:  is_normal = 1'b0;
      default: is_normal = 1'b1;
    endcase
  end

  always_comb begin
    rsp_o          = '0;
    rsp_o.status   = ST_IGNORED;
    mode_d         = is_normal ? NORMAL : mode_q;
    cnt_d          = cnt_q;
    pend_d         = pend_q;
    entry_we       = 1'b0;
    store_we       = 1'b0;
    case (item_i.req_type)
      REQ_KEY: begin
        if (is_normal && (item_i.key_code == KEY_HASH)) begin
          cnt_d        = '0;
          mode_d       = OLD_PW;
          rsp_o.status = ST_CHANGE;
        end else if (is_digit) begin
          rsp_o.digit_position = POS_W'(cnt_q);
          rsp_o.status         = ST_DIGIT;
          entry_we             = 1'b1;
          cnt_d                = cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            cnt_d = '0;
            case (mode_q)
              OLD_PW: begin
                if (match) begin
                  mode_d       = NEW_PW;
                  rsp_o.status = ST_NEWPROMPT;
                end else begin
                  mode_d       = NORMAL;
                  rsp_o.status = ST_WRONGOLD;
                  rsp_o.unlock = pend_q;
                  pend_d       = 1'b0;
                end
              end
              NEW_PW: begin
                store_we     = 1'b1;
                mode_d       = NORMAL;
                rsp_o.status = ST_CHANGED;
                rsp_o.unlock = pend_q;
                pend_d       = 1'b0;
              end
              default: begin
                if (match) begin
                  rsp_o.status = ST_GRANTED;
                  rsp_o.unlock = 1'b1;
                end else begin
                  rsp_o.status = ST_DENIED;
                end
              end
            endcase
          end
        end
      end
      REQ_CARD: begin
        if (is_normal) begin
          if (item_i.card_id == card_uid_q) begin
            rsp_o.status = ST_GRANTED;
            rsp_o.unlock = 1'b1;
          end else begin
            rsp_o.status = ST_DENIED;
          end
        end
      end
      REQ_LINK: begin
        if (item_i.link_byte == LINK_UNLOCK) begin
          if (is_normal) begin
            rsp_o.status = ST_GRANTED;
            rsp_o.unlock = 1'b1;
          end else begin
            pend_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp_o.lock_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= NORMAL;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      card_uid_q <= CARD_UID_RESET;
      for (int i = 0; i < CODE_LEN; i++) begin
        stored_q[i] <= reset_digit(i);
      end
    end else begin
      if (cfg_we_i) begin
        card_uid_q <= cfg_wdata_i;
      end
      if (step_i) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
        pend_q <= pend_d;
        if (store_we) begin
          for (int i = 0; i < CODE_LEN; i++) begin
            stored_q[i] <= entry_nx[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && entry_we) begin
      entry_q[cnt_q] <= digit;
    end
  end

endmodule

FILE: sv/keypad_code_lock_controller.sv
// Top level of the keypad code-lock controller.
//
//   Channel   Dir   Handshake      Word contents
//   req_i     in    valid/ready    req_type, key_code, card_id, link_byte
//   rsp_o     out   valid/ready    status, digit_position, lock_mode, unlock
//   cfg       in    write enable   card_uid
//
// Each request word passes an input register and is resolved combinationally by the
// state machine into the output register, from which its response is presented. One
// word is taken every cycle unless the response stalls. Reset clears both stages and
// returns to normal mode with the factory password. A stalled response holds the
// output register and, once the input register is also full, stops taking requests.
module keypad_code_lock_controller #(
  parameter int CODE_LEN = kcl_pkg::CODE_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kcl_pkg::CARD_W-1:0] cfg_wdata_i,
  kcl_req_if.sink                    req_i,
  kcl_rsp_if.source                  rsp_o
);
  import kcl_pkg::*;

  req_t in_item;
  req_t s1_item;
  rsp_t fsm_rsp;
  rsp_t out_rsp;
  logic s1_valid;
  logic s2_ready;
  logic step;

  assign in_item.req_type  = req_i.req_type;
  assign in_item.key_code  = req_i.key_code;
  assign in_item.card_id   = req_i.card_id;
  assign in_item.link_byte = req_i.link_byte;

  assign step = s1_valid && s2_ready;

  kcl_stage #(.T(req_t)) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (in_item),
    .out_valid_o (s1_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s1_item)
  );

  kcl_fsm #(.CODE_LEN(CODE_LEN)) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (s1_item),
    .rsp_o       (fsm_rsp)
  );

  kcl_stage #(.T(rsp_t)) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (fsm_rsp),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (out_rsp)
  );

  assign rsp_o.status         = out_rsp.status;
  assign rsp_o.digit_position = out_rsp.digit_position;
  assign rsp_o.lock_mode      = out_rsp.lock_mode;
  assign rsp_o.unlock         = out_rsp.unlock;

endmodule

FILE: sv/kcl_checker.sv
// Port-level assertions for the keypad code-lock controller and their binding.
module kcl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [kcl_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [kcl_pkg::POS_W-1:0]    rsp_digit_position_i,
  input logic [kcl_pkg::MODE_W-1:0]   rsp_lock_mode_i,
  input logic                         rsp_unlock_i
);
  import kcl_pkg::*;

  // A stalled response word keeps its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_digit_position_i) &&
      $stable(rsp_lock_mode_i) && $stable(rsp_unlock_i))
    else $error("response word changed while stalled");

  // Every accepted request is followed by a valid response word on the port once it has passed both registers.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> ##1 rsp_valid_i)
    else $error("accepted request produced no response word");

  // The lock opens only on a grant or at the end of a password change, also one that fails on the old password.
  a_unlock_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_unlock_i |->
      (rsp_status_i == ST_GRANTED) || (rsp_status_i == ST_CHANGED) ||
      (rsp_status_i == ST_WRONGOLD))
    else $error("unlock asserted with an unexpected status");

  // Mode reported after a change step matches the step taken.
  a_mode_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((rsp_status_i != ST_CHANGE) || (rsp_lock_mode_i == LM_OLD)) &&
      ((rsp_status_i != ST_NEWPROMPT) || (rsp_lock_mode_i == LM_NEW)) &&
      ((rsp_status_i != ST_CHANGED) || (rsp_lock_mode_i == LM_NORMAL)) &&
      ((rsp_status_i != ST_WRONGOLD) || (rsp_lock_mode_i == LM_NORMAL)))
    else $error("lock mode does not match status");

endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_status_i         (rsp_o.status),
  .rsp_digit_position_i (rsp_o.digit_position),
  .rsp_lock_mode_i      (rsp_o.lock_mode),
  .rsp_unlock_i         (rsp_o.unlock)
);

FILE: test/testbench.sv
// Self-checking testbench for the keypad code-lock controller, with its own lock state predictor.
module testbench;
  import kcl_pkg::*;

  localparam int CODE_LEN    = CODE_LEN_DEF;
  localparam int CNT_W       = $clog2(CODE_LEN + 1);
  localparam int IDLE_PCT    = 21;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_WORDS = 335;
  localparam int TIMEOUT     = 1600000;

  typedef struct packed {
    logic [MODE_W-1:0]                mode;
    logic [CNT_W-1:0]                 count;
    logic [CODE_LEN-1:0][DIGIT_W-1:0] entry;
    logic [CODE_LEN-1:0][DIGIT_W-1:0] pwd;
    logic                             pending;
  } lock_state_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CARD_W-1:0] cfg_wdata = '0;
  logic              req_valid = 1'b0;
  req_t              req_word = '0;
  logic              rsp_ready = 1'b0;

  kcl_req_if req_if ();
  kcl_rsp_if rsp_if ();

  assign req_if.valid     = req_valid;
  assign req_if.req_type  = req_word.req_type;
  assign req_if.key_code  = req_word.key_code;
  assign req_if.card_id   = req_word.card_id;
  assign req_if.link_byte = req_word.link_byte;
  assign rsp_if.ready     = rsp_ready;

  keypad_code_lock_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  req_t              pending_words[$];
  rsp_t              expected_rsps[$];
  lock_state_t       gen_state;
  lock_state_t       chk_state;
  logic [CARD_W-1:0] card_uid_cfg = CARD_UID_RESET;
  int                counted_words = 0;
  int                error_count = 0;
  bit                steady = 1'b0;
  int                hold_left = 0;
  int                holds_asked = 0;
  int                holds_done = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic lock_state_t lock_reset_state();
    lock_state_t s;
    s = '0;
    s.mode = LM_NORMAL;
    for (int i = 0; i < CODE_LEN; i++) begin
      s.pwd[i] = DIGIT_W'((i % 9) + 1);
    end
    return s;
  endfunction

  // Advances one lock state by one word and returns the response it produces.
  function automatic rsp_t lock_step(inout lock_state_t s, input req_t r,
                                     input logic [CARD_W-1:0] uid);
    rsp_t        o;
    bit          normal;
    logic [7:0]  d;
    o = '0;
    o.status = ST_IGNORED;
    normal = (s.mode != LM_OLD && s.mode != LM_NEW);
    if (normal) s.mode = LM_NORMAL;
    case (r.req_type)
      REQ_KEY: begin
        if (normal && r.key_code == KEY_HASH) begin
          s.count = '0;
          s.entry = '0;
          s.mode = LM_OLD;
          o.status = ST_CHANGE;
        end else if (r.key_code >= KEY_ZERO && r.key_code <= KEY_NINE) begin
          if (s.count >= CODE_LEN) begin
            s.count = '0;
            s.entry = '0;
          end
          o.digit_position = POS_W'(s.count);
          d = r.key_code - KEY_ZERO;
          s.entry[s.count] = d[DIGIT_W-1:0];
          s.count = s.count + 1'b1;
          o.status = ST_DIGIT;
          if (s.count == CODE_LEN) begin
            if (s.mode == LM_OLD) begin
              if (s.entry == s.pwd) begin
                s.mode = LM_NEW;
                o.status = ST_NEWPROMPT;
              end else begin
                s.mode = LM_NORMAL;
                o.status = ST_WRONGOLD;
              end
            end else if (s.mode == LM_NEW) begin
              s.pwd = s.entry;
              s.mode = LM_NORMAL;
              o.status = ST_CHANGED;
            end else if (s.entry == s.pwd) begin
              o.status = ST_GRANTED;
              o.unlock = 1'b1;
            end else begin
              o.status = ST_DENIED;
            end
            s.count = '0;
            s.entry = '0;
            if (o.status == ST_WRONGOLD || o.status == ST_CHANGED) begin
              o.unlock = s.pending;
              s.pending = 1'b0;
            end
          end
        end
      end
      REQ_CARD: begin
        if (normal) begin
          if (r.card_id == uid) begin
            o.status = ST_GRANTED;
            o.unlock = 1'b1;
          end else begin
            o.status = ST_DENIED;
          end
        end
      end
      REQ_LINK: begin
        if (r.link_byte == LINK_UNLOCK) begin
          if (normal) begin
            o.status = ST_GRANTED;
            o.unlock = 1'b1;
          end else begin
            s.pending = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.lock_mode = s.mode;
    return o;
  endfunction

  function automatic req_t key_word(input logic [BYTE_W-1:0] k);
    req_t r;
    r.req_type = REQ_KEY;
    r.key_code = k;
    r.card_id = $urandom;
    r.link_byte = BYTE_W'($urandom_range(255));
    return r;
  endfunction

  function automatic req_t digit_word(input int unsigned d);
    return key_word(KEY_ZERO + BYTE_W'(d));
  endfunction

  function automatic req_t card_word(input logic [CARD_W-1:0] c);
    req_t r;
    r.req_type = REQ_CARD;
    r.key_code = BYTE_W'($urandom_range(255));
    r.card_id = c;
    r.link_byte = BYTE_W'($urandom_range(255));
    return r;
  endfunction

  function automatic req_t link_word(input logic [BYTE_W-1:0] b);
    req_t r;
    r.req_type = REQ_LINK;
    r.key_code = BYTE_W'($urandom_range(255));
    r.card_id = $urandom;
    r.link_byte = b;
    return r;
  endfunction

  task automatic offer(input req_t r);
    rsp_t o;
    o = lock_step(gen_state, r, card_uid_cfg);
    if (o.status != ST_IGNORED) counted_words++;
    pending_words.push_back(r);
  endtask

  task automatic offer_keys(input string s);
    for (int i = 0; i < s.len(); i++) begin
      offer(key_word(s[i]));
    end
  endtask

  // Finishes any open entry so that the lock is in normal mode with no digits taken.
  task automatic settle_entry();
    while (gen_state.mode != LM_NORMAL || gen_state.count != 0) begin
      offer(digit_word($urandom_range(9)));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int target);
    int                               goal;
    int unsigned                      kind;
    int unsigned                      link_at;
    logic [CODE_LEN-1:0][DIGIT_W-1:0] code;
    req_t                             r;
    goal = counted_words + target;
    while (counted_words < goal) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        settle_entry();
        code = gen_state.pwd;
        for (int i = 0; i < CODE_LEN; i++) begin
          if ($urandom_range(7) == 0) offer(card_word($urandom));
          offer(digit_word(code[i]));
        end
      end else if (kind < 45) begin
        settle_entry();
        for (int i = 0; i < CODE_LEN; i++) begin
          offer(digit_word($urandom_range(9)));
        end
      end else if (kind < 62) begin
        settle_entry();
        offer(key_word(KEY_HASH));
        link_at = $urandom_range(CODE_LEN + 1);
        code = gen_state.pwd;
        if ($urandom_range(3) == 0) begin
          for (int i = 0; i < CODE_LEN; i++) code[i] = DIGIT_W'($urandom_range(9));
        end
        for (int i = 0; i < CODE_LEN; i++) begin
          if (link_at == i) offer(link_word(LINK_UNLOCK));
          offer(digit_word(code[i]));
        end
        if (gen_state.mode == LM_NEW) begin
          for (int i = 0; i < CODE_LEN; i++) begin
            if (link_at == CODE_LEN && i == CODE_LEN / 2) offer(link_word(LINK_UNLOCK));
            offer(digit_word($urandom_range(9)));
          end
        end
      end else if (kind < 72) begin
        offer(card_word($urandom_range(1) ? card_uid_cfg : $urandom));
      end else if (kind < 80) begin
        offer(link_word($urandom_range(1) ? LINK_UNLOCK : BYTE_W'($urandom_range(255))));
      end else if (kind < 88) begin
        for (int i = $urandom_range(1, CODE_LEN - 1); i > 0; i--) begin
          offer(digit_word($urandom_range(9)));
        end
        if ($urandom_range(1)) offer(key_word(KEY_HASH));
      end else begin
        r.req_type = REQ_W'($urandom_range(3));
        r.key_code = BYTE_W'($urandom_range(255));
        r.card_id = $urandom;
        r.link_byte = BYTE_W'($urandom_range(255));
        offer(r);
      end
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Request driver: the prediction is made when a word is taken by the block.
  always @(posedge clk_i) begin
    req_t next_word;
    if (rst_ni) begin
      if (req_valid && req_if.ready) begin
        expected_rsps.push_back(lock_step(chk_state, req_word, card_uid_cfg));
      end
      if (!req_valid || req_if.ready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_word = pending_words.pop_front();
          req_word <= next_word;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Response monitor and ready generator.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_error($sformatf("response word with status %0d while none was expected",
                                 rsp_if.status));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.status !== want.status)
            report_error($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
          if (rsp_if.digit_position !== want.digit_position)
            report_error($sformatf("digit_position %0d, expected %0d",
                                   rsp_if.digit_position, want.digit_position));
          if (rsp_if.lock_mode !== want.lock_mode)
            report_error($sformatf("lock_mode %0d, expected %0d",
                                   rsp_if.lock_mode, want.lock_mode));
          if (rsp_if.unlock !== want.unlock)
            report_error($sformatf("unlock %0d, expected %0d", rsp_if.unlock, want.unlock));
        end
      end
      rsp_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #(TIMEOUT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [CARD_W-1:0] uid_values[4];
    gen_state = lock_reset_state();
    chk_state = lock_reset_state();
    uid_values[0] = '0;
    uid_values[1] = '1;
    uid_values[2] = $urandom;
    uid_values[3] = CARD_UID_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: factory code, ignored keys, change flow with a held link unlock,
    // cards and link bytes, and a partial entry that survives a card read.
    offer_keys("1234");
    offer(key_word('0));
    offer(key_word('1));
    offer_keys("5");
    offer(key_word(KEY_HASH));
    offer(card_word('1));
    offer(link_word(LINK_UNLOCK));
    offer(key_word(KEY_HASH));
    offer_keys("1234");
    offer_keys("9009");
    offer(card_word(CARD_UID_RESET));
    offer_keys("9");
    offer(card_word('0));
    offer_keys("009");
    offer(link_word(LINK_UNLOCK));
    offer(link_word('1));
    offer(key_word(KEY_HASH) ^ {REQ_W'(3), {(BYTE_W * 2 + CARD_W){1'b0}}});
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_wdata <= uid_values[p];
      @(posedge clk_i);
      cfg_we <= 1'b0;
      card_uid_cfg = uid_values[p];
      if (p == 0) holds_asked++;
      if (p == 1) steady = 1'b1;
      random_traffic(PHASE_WORDS);
      wait_drained();
      steady = 1'b0;
    end

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/kcl_pkg.sv
sv/kcl_if.sv
sv/kcl_stage.sv
sv/kcl_fsm.sv
sv/keypad_code_lock_controller.sv
sv/kcl_checker.sv
test/testbench.sv
